// ===== src/llv_pkg.sv =====
// Package for the log line validator: line state types, character codes
// and the per-beat result struct. No dependencies.
package llv_pkg;

  localparam logic [7:0] CharLf    = 8'd10;
  localparam logic [7:0] CharTab   = 8'd9;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharSep   = 8'd32;
  localparam logic [7:0] CharDash  = 8'h2d;  // '-'
  localparam logic [7:0] CharT     = 8'h54;  // 'T'
  localparam logic [7:0] CharColon = 8'h3a;  // ':'
  localparam logic [7:0] CharPoint = 8'h2e;  // '.'
  localparam logic [7:0] CharPlus  = 8'h2b;  // '+'
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'

  localparam logic [4:0] StampLen  = 5'd19;

  typedef enum logic [2:0] {
    PH_STAMP = 3'd0,
    PH_GAP1  = 3'd1,
    PH_NAME  = 3'd2,
    PH_GAP2  = 3'd3,
    PH_NUM   = 3'd4,
    PH_TAIL  = 3'd5,
    PH_FAIL  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    NUM_START = 2'd0,
    NUM_SIGN  = 2'd1,
    NUM_INT   = 2'd2,
    NUM_FRAC  = 2'd3
  } num_e;

  typedef struct packed {
    phase_e     phase;
    logic [4:0] stamp_pos;
    num_e       num;
  } llv_state_t;

  localparam llv_state_t StateReset = '{phase: PH_STAMP, stamp_pos: 5'd0, num: NUM_START};

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       is_verdict;
    logic       line_ok;
  } llv_result_t;

endpackage

// ===== src/llv_parse.sv =====
// Per-character line checker: next line state and the result beat for one byte.
// Depends on llv_pkg.
module llv_parse (
  input  logic [7:0]          in_byte_i,
  input  llv_pkg::llv_state_t state_i,
  output llv_pkg::llv_state_t state_o,
  output llv_pkg::llv_result_t result_o
);

  function automatic logic is_digit(logic [7:0] c);
    return (c >= llv_pkg::CharZero) && (c <= llv_pkg::CharNine);
  endfunction

  function automatic logic stamp_ok(logic [4:0] pos, logic [7:0] c);
    logic ok;
    if (pos >= llv_pkg::StampLen) begin
      ok = 1'b0;
    end else if (pos == 5'd4 || pos == 5'd7) begin
      ok = (c == llv_pkg::CharDash);
    end else if (pos == 5'd10) begin
      ok = (c == llv_pkg::CharT);
    end else if (pos == 5'd13 || pos == 5'd16) begin
      ok = (c == llv_pkg::CharColon);
    end else begin
      ok = is_digit(c);
    end
    return ok;
  endfunction

  logic blank;
  logic num_ok;
  llv_pkg::num_e num_next;

  assign blank = in_byte_i inside {llv_pkg::CharSep, llv_pkg::CharTab, llv_pkg::CharCr};

  always_comb begin
    num_next = state_i.num;
    num_ok   = 1'b0;
    case (state_i.num)
      llv_pkg::NUM_START: begin
        if (in_byte_i == llv_pkg::CharDash || in_byte_i == llv_pkg::CharPlus) begin
          num_next = llv_pkg::NUM_SIGN;
          num_ok   = 1'b1;
        end else if (is_digit(in_byte_i)) begin
          num_next = llv_pkg::NUM_INT;
          num_ok   = 1'b1;
        end
      end
      llv_pkg::NUM_SIGN: begin
        if (is_digit(in_byte_i)) begin
          num_next = llv_pkg::NUM_INT;
          num_ok   = 1'b1;
        end
      end
      llv_pkg::NUM_INT: begin
        if (in_byte_i == llv_pkg::CharPoint) begin
          num_next = llv_pkg::NUM_FRAC;
          num_ok   = 1'b1;
        end else begin
          num_ok = is_digit(in_byte_i);
        end
      end
      default: begin
        num_ok = is_digit(in_byte_i);
      end
    endcase
  end

  always_comb begin
    state_o             = state_i;
    result_o.valid      = 1'b1;
    result_o.out_byte   = in_byte_i;
    result_o.is_verdict = 1'b0;
    result_o.line_ok    = 1'b0;

    if (in_byte_i == llv_pkg::CharLf) begin
      result_o.out_byte   = 8'd0;
      result_o.is_verdict = 1'b1;
      result_o.line_ok    = (state_i.phase == llv_pkg::PH_NUM) ||
                            (state_i.phase == llv_pkg::PH_TAIL);
      state_o             = llv_pkg::StateReset;
    end else begin
      case (state_i.phase)
        llv_pkg::PH_STAMP: begin
          if (blank) begin
            state_o.phase     = llv_pkg::PH_GAP1;
            result_o.out_byte = llv_pkg::CharSep;
          end else if (stamp_ok(state_i.stamp_pos, in_byte_i)) begin
            state_o.stamp_pos = state_i.stamp_pos + 5'd1;
          end else begin
            state_o.phase  = llv_pkg::PH_FAIL;
            result_o.valid = 1'b0;
          end
        end
        llv_pkg::PH_GAP1: begin
          if (blank) begin
            result_o.valid = 1'b0;
          end else begin
            state_o.phase = llv_pkg::PH_NAME;
          end
        end
        llv_pkg::PH_NAME: begin
          if (blank) begin
            state_o.phase     = llv_pkg::PH_GAP2;
            result_o.out_byte = llv_pkg::CharSep;
          end
        end
        llv_pkg::PH_GAP2, llv_pkg::PH_NUM: begin
          if (blank) begin
            // drop blanks; in PH_NUM one ends the number and the line's rest
            if (state_i.phase == llv_pkg::PH_NUM) begin
              state_o.phase = llv_pkg::PH_TAIL;
            end
            result_o.valid = 1'b0;
          end else if (num_ok) begin
            state_o.phase = llv_pkg::PH_NUM;
            state_o.num   = num_next;
          end else begin
            state_o.phase  = llv_pkg::PH_FAIL;
            result_o.valid = 1'b0;
          end
        end
        default: begin
          result_o.valid = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== src/log_line_validator.sv =====
// Top level of the log line validator: input register, line state register
// and result register around llv_parse. Depends on llv_pkg and llv_parse.
//
//   channel  dir  tdata                tlast        tuser
//   s_axis   in   [7:0] in_byte        -            -
//   m_axis   out  [7:0] out_byte       is_verdict   [0] line_ok
//
// Each byte passes through the input register, then through the checker into
// the result register. Throughput is one byte per cycle while m_axis_tready_i
// does not hold the result register; the line state loop is a single register.
// Reset puts the line state at the start of a timestamp and empties both
// registers. When the result register is held by m_axis_tready_i low, the
// input register still takes one more beat before s_axis_tready_o drops.
module log_line_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // is_verdict
  output logic       m_axis_tuser_o    // [0] line_ok
);

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  llv_pkg::llv_state_t  state_q, state_d;
  llv_pkg::llv_result_t result;
  logic                 out_valid_q;
  logic [7:0]           out_byte_q;
  logic                 out_last_q;
  logic                 out_ok_q;
  logic                 advance;

  llv_parse u_parse (
    .in_byte_i (in_byte_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .result_o  (result)
  );

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // advance the line state only when the buffered beat moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= llv_pkg::StateReset;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && result.valid;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_byte_q <= result.out_byte;
      out_last_q <= result.is_verdict;
      out_ok_q   <= result.line_ok;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_ok_q;

endmodule
